// ----- rtl/constant_velocity_kalman_filter_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Kalman filter unit.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_VELOCITY_KALMAN_FILTER_UNIT_ASSERT_SVH
`define CONSTANT_VELOCITY_KALMAN_FILTER_UNIT_ASSERT_SVH

// same-cycle implication
`define CVKF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CVKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cvkf_pkg.sv -----
// ---------------------------------------------------------------------------
// cvkf_pkg
// Types and constants shared by the Kalman filter unit and its lanes.
// ---------------------------------------------------------------------------
package cvkf_pkg;

  localparam int unsigned STATE_DIM = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [WORD_W-1:0] quo;
  } div_res_t;

endpackage

// ----- rtl/cvkf_mac_lane.sv -----
// ---------------------------------------------------------------------------
// cvkf_mac_lane
// One product lane: registered multiply, then round half up to fixed point.
// ---------------------------------------------------------------------------
module cvkf_mac_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  cvkf_pkg::word_t                               a_i,
  input  cvkf_pkg::word_t                               b_i,
  output logic signed [2*cvkf_pkg::WORD_W-FRAC_BITS-1:0] term_o
);
  import cvkf_pkg::*;

  localparam int unsigned PW = 2 * WORD_W;
  localparam int unsigned TW = PW - FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] shf;
  logic signed [TW-1:0] term_q;

  assign rnd = prod_q + HALF;
  assign shf = rnd >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(a_i) * PW'(b_i);
    term_q <= shf[TW-1:0];
  end

  assign term_o = term_q;

endmodule

// ----- rtl/cvkf_div_lane.sv -----
// ---------------------------------------------------------------------------
// cvkf_div_lane
// Fixed-point divide lane: restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cvkf_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cvkf_pkg::word_t      numer_i,
  input  cvkf_pkg::word_t      denom_i,
  output cvkf_pkg::div_res_t   res_o
);
  import cvkf_pkg::*;

  localparam int unsigned NW = WORD_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]     n_q, q_q;
  logic [WORD_W-1:0] den_q, rem_q;
  logic              neg_q, busy_q, done_q;
  logic [CW-1:0]     cnt_q;

  logic [WORD_W-1:0] num_mag, den_mag;
  logic [WORD_W:0]   rem_sh;
  logic              ge;
  logic [WORD_W:0]   rem_d;
  logic              pos_sat, neg_sat;

  assign num_mag = numer_i[WORD_W-1] ? WORD_W'(-numer_i) : WORD_W'(numer_i);
  assign den_mag = denom_i[WORD_W-1] ? WORD_W'(-denom_i) : WORD_W'(denom_i);
  assign rem_sh  = {rem_q, n_q[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_d   = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  assign pos_sat = |q_q[NW-1:WORD_W-1];
  assign neg_sat = (|q_q[NW-1:WORD_W]) ||
                   (q_q[WORD_W-1] && (|q_q[WORD_W-2:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {num_mag, {FRAC_BITS{1'b0}}};
      q_q   <= '0;
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= numer_i[WORD_W-1] ^ denom_i[WORD_W-1];
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], 1'b0};
      q_q   <= {q_q[NW-2:0], ge};
      rem_q <= rem_d[WORD_W-1:0];
    end
  end

  always_comb begin
    res_o.done = done_q;
    if (neg_q) begin
      res_o.sat = neg_sat;
      res_o.quo = neg_sat ? {1'b1, {(WORD_W-1){1'b0}}} : WORD_W'(-q_q[WORD_W-1:0]);
    end else begin
      res_o.sat = pos_sat;
      res_o.quo = pos_sat ? {1'b0, {(WORD_W-1){1'b1}}} : q_q[WORD_W-1:0];
    end
  end

endmodule

// ----- rtl/constant_velocity_kalman_filter_unit.sv -----
// ---------------------------------------------------------------------------
// constant_velocity_kalman_filter_unit
// Predict forms two 4x4 products on four product lanes; update time is set
// by the divide lanes, pivot column by pivot column, and is shorter on a
// zero pivot. One transaction at a time; the next can be accepted in the
// same cycle as the result is presented.
// Reset: estimate zero, covariance identity, registers at 1.0.
// ---------------------------------------------------------------------------
`include "constant_velocity_kalman_filter_unit_assert.svh"

module constant_velocity_kalman_filter_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cvkf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cvkf_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cvkf_pkg::CMD_W-1:0]          command_i,
  input  cvkf_pkg::word_t                     measured_pos_x_i,
  input  cvkf_pkg::word_t                     measured_pos_y_i,
  input  cvkf_pkg::word_t                     measured_vel_x_i,
  input  cvkf_pkg::word_t                     measured_vel_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cvkf_pkg::word_t                     est_pos_x_o,
  output cvkf_pkg::word_t                     est_pos_y_o,
  output cvkf_pkg::word_t                     est_vel_x_o,
  output cvkf_pkg::word_t                     est_vel_y_o,
  output logic                                singular_o,
  output logic                                saturated_o
);
  import cvkf_pkg::*;

  localparam int unsigned TW = 2 * WORD_W - FRAC_BITS;
  localparam int unsigned SW = TW + 2;
  localparam word_t ONE_FX = WORD_W'(1) << FRAC_BITS;
  localparam word_t W_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t W_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [CFG_W-1:0] CFG_ONE = CFG_W'(1) << FRAC_BITS;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RST    = 4'd1;
  localparam logic [3:0] ST_PEST   = 4'd2;
  localparam logic [3:0] ST_MM1    = 4'd3;
  localparam logic [3:0] ST_MM2    = 4'd4;
  localparam logic [3:0] ST_UY     = 4'd5;
  localparam logic [3:0] ST_PIV    = 4'd6;
  localparam logic [3:0] ST_DIVA   = 4'd7;
  localparam logic [3:0] ST_DIVB   = 4'd8;
  localparam logic [3:0] ST_ELIM   = 4'd9;
  localparam logic [3:0] ST_MMK    = 4'd10;
  localparam logic [3:0] ST_NX     = 4'd11;
  localparam logic [3:0] ST_IK     = 4'd12;
  localparam logic [3:0] ST_MMP    = 4'd13;
  localparam logic [3:0] ST_COMMIT = 4'd14;
  localparam logic [3:0] ST_DONE   = 4'd15;

  function automatic logic [WORD_W:0] sat_w(input logic signed [SW-1:0] v);
    logic ovf;
    ovf = !((&v[SW-1:WORD_W-1]) || !(|v[SW-1:WORD_W-1]));
    if (ovf) return {1'b1, (v[SW-1] ? W_MIN : W_MAX)};
    return {1'b0, v[WORD_W-1:0]};
  endfunction

  function automatic logic [WORD_W:0] add_sat(input word_t a, input word_t b,
                                               input logic sub);
    logic signed [WORD_W:0] s;
    s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
    if (s[WORD_W] != s[WORD_W-1]) return {1'b1, (s[WORD_W] ? W_MIN : W_MAX)};
    return {1'b0, s[WORD_W-1:0]};
  endfunction

  function automatic logic [WORD_W:0] mag(input word_t a);
    logic signed [WORD_W:0] x;
    x = {a[WORD_W-1], a};
    return a[WORD_W-1] ? (WORD_W+1)'(-x) : x;
  endfunction

  function automatic word_t f_el(input logic [1:0] i, input logic [1:0] k, input word_t dt);
    if (i == k) return ONE_FX;
    if ((i == 2'd0 && k == 2'd2) || (i == 2'd1 && k == 2'd3)) return dt;
    return '0;
  endfunction

  logic [3:0]          state_q;
  logic [3:0]          e_q;
  logic [1:0]          ph_q;
  logic [1:0]          col_q;
  logic [CMD_W-1:0]    cmd_q;
  logic                sat_q, sing_q;
  logic [CFG_W-1:0]    ts_q, iv_q, nl_q;
  word_t               est_q [STATE_DIM];
  word_t               y_q [STATE_DIM];
  word_t               p_q [16];
  word_t               t_q [16];
  word_t               a_q [16];
  word_t               b_q [16];
  word_t               k_q [16];
  word_t               pv_q, f_q;

  logic                out_valid_q;
  word_t               out_est_q [STATE_DIM];
  logic                out_sing_q, out_sat_q;

  word_t               la [STATE_DIM];
  word_t               lb [STATE_DIM];
  logic signed [TW-1:0] lt [STATE_DIM];
  logic signed [SW-1:0] sum;
  logic [WORD_W:0]     sum_sat;

  logic [1:0]          ei, ej, er;
  logic                eh;
  word_t               dt, nl;

  logic [1:0]          piv;
  word_t               piv_val;
  logic                div_start;
  word_t               div_num [STATE_DIM];
  word_t               div_den;
  div_res_t            div_res [STATE_DIM];
  logic                accept;

  assign ei = e_q[3:2];
  assign ej = e_q[1:0];
  assign er = e_q[2:1];
  assign eh = e_q[0];
  assign dt = {1'b0, ts_q};
  assign nl = {1'b0, nl_q};

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    for (int k = 0; k < STATE_DIM; k++) begin
      la[k] = '0;
      lb[k] = '0;
    end
    unique case (state_q)
      ST_PEST: begin
        la[0] = dt;
        lb[0] = est_q[2];
        la[1] = dt;
        lb[1] = est_q[3];
      end
      ST_MM1: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = f_el(ei, 2'(k), dt);
          lb[k] = p_q[{2'(k), ej}];
        end
      end
      ST_MM2: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = t_q[{ei, 2'(k)}];
          lb[k] = f_el(ej, 2'(k), dt);
        end
      end
      ST_ELIM: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = eh ? f_q : a_q[{er, col_q}];
          lb[k] = eh ? b_q[{col_q, 2'(k)}] : a_q[{col_q, 2'(k)}];
        end
      end
      ST_MMK: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = p_q[{ei, 2'(k)}];
          lb[k] = b_q[{2'(k), ej}];
        end
      end
      ST_NX: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = k_q[{ej, 2'(k)}];
          lb[k] = y_q[k];
        end
      end
      ST_MMP: begin
        for (int k = 0; k < STATE_DIM; k++) begin
          la[k] = k_q[{ei, 2'(k)}];
          lb[k] = p_q[{2'(k), ej}];
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < STATE_DIM; g++) begin : g_lane
    cvkf_mac_lane #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clk_i  (clk_i),
      .a_i    (la[g]),
      .b_i    (lb[g]),
      .term_o (lt[g])
    );
    cvkf_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .numer_i (div_num[g]),
      .denom_i (div_den),
      .res_o   (div_res[g])
    );
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < STATE_DIM; k++) begin
      sum = sum + SW'(lt[k]);
    end
    sum_sat = sat_w(sum);
  end

  always_comb begin
    piv = col_q;
    for (int r = 1; r < STATE_DIM; r++) begin
      if (2'(r) > col_q && mag(a_q[{2'(r), col_q}]) > mag(a_q[{piv, col_q}])) begin
        piv = 2'(r);
      end
    end
    piv_val = a_q[{piv, col_q}];
  end

  always_comb begin
    div_start = (state_q == ST_PIV && piv_val != '0) ||
                (state_q == ST_DIVA && div_res[0].done);
    div_den   = (state_q == ST_PIV) ? piv_val : pv_q;
    for (int j = 0; j < STATE_DIM; j++) begin
      div_num[j] = (state_q == ST_PIV) ? a_q[{piv, 2'(j)}] : b_q[{col_q, 2'(j)}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin : seq_p
    logic            hit;
    logic [WORD_W:0] r0, r1;
    logic [WORD_W:0] ts;
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      e_q         <= '0;
      ph_q        <= '0;
      col_q       <= '0;
      cmd_q       <= CMD_RESTART;
      sat_q       <= 1'b0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ts_q        <= CFG_ONE;
      iv_q        <= CFG_ONE;
      nl_q        <= CFG_ONE;
      for (int i = 0; i < STATE_DIM; i++) begin
        est_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        p_q[i] <= (i % 5 == 0) ? ONE_FX : '0;
      end
    end else begin
      hit = 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TIME_STEP: ts_q <= cfg_data_i;
          CFG_INIT_VAR:  iv_q <= cfg_data_i;
          CFG_NOISE:     nl_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (ph_q == 2'd2) begin
        ph_q <= '0;
        e_q  <= e_q + 4'd1;
      end else begin
        ph_q <= ph_q + 2'd1;
      end

      unique case (state_q)
        ST_IDLE: begin
          ph_q <= '0;
          e_q  <= '0;
          if (accept) begin
            cmd_q  <= command_i;
            sat_q  <= 1'b0;
            sing_q <= 1'b0;
            col_q  <= '0;
            y_q[0] <= measured_pos_x_i;
            y_q[1] <= measured_pos_y_i;
            y_q[2] <= measured_vel_x_i;
            y_q[3] <= measured_vel_y_i;
            unique case (command_i)
              CMD_RESTART: state_q <= ST_RST;
              CMD_PREDICT: state_q <= ST_PEST;
              CMD_UPDATE:  state_q <= ST_UY;
              default:     state_q <= ST_DONE;
            endcase
          end
        end
        ST_RST: begin
          for (int i = 0; i < STATE_DIM; i++) begin
            est_q[i] <= '0;
          end
          for (int i = 0; i < 16; i++) begin
            p_q[i] <= (i % 5 == 0) ? word_t'({1'b0, iv_q}) : '0;
          end
          state_q <= ST_DONE;
        end
        ST_PEST: begin
          if (ph_q == 2'd2) begin
            r0 = sat_w(SW'(lt[0]));
            r1 = sat_w(SW'(lt[1]));
            hit = hit | r0[WORD_W] | r1[WORD_W];
            r0 = add_sat(est_q[0], r0[WORD_W-1:0], 1'b0);
            r1 = add_sat(est_q[1], r1[WORD_W-1:0], 1'b0);
            hit = hit | r0[WORD_W] | r1[WORD_W];
            est_q[0] <= r0[WORD_W-1:0];
            est_q[1] <= r1[WORD_W-1:0];
            e_q      <= '0;
            state_q  <= ST_MM1;
          end
        end
        ST_MM1: begin
          if (ph_q == 2'd2) begin
            hit = hit | sum_sat[WORD_W];
            t_q[e_q] <= sum_sat[WORD_W-1:0];
            if (e_q == 4'd15) state_q <= ST_MM2;
          end
        end
        ST_MM2: begin
          if (ph_q == 2'd2) begin
            hit = hit | sum_sat[WORD_W];
            if (ei == ej) begin
              r0 = add_sat(sum_sat[WORD_W-1:0], nl, 1'b0);
              hit = hit | r0[WORD_W];
              p_q[e_q] <= r0[WORD_W-1:0];
            end else begin
              p_q[e_q] <= sum_sat[WORD_W-1:0];
            end
            if (e_q == 4'd15) state_q <= ST_DONE;
          end
        end
        ST_UY: begin
          for (int i = 0; i < STATE_DIM; i++) begin
            r0 = add_sat(y_q[i], est_q[i], 1'b1);
            hit = hit | r0[WORD_W];
            y_q[i] <= r0[WORD_W-1:0];
          end
          for (int i = 0; i < 16; i++) begin
            if (i % 5 == 0) begin
              r0 = add_sat(p_q[i], nl, 1'b0);
              hit = hit | r0[WORD_W];
              a_q[i] <= r0[WORD_W-1:0];
              b_q[i] <= ONE_FX;
            end else begin
              a_q[i] <= p_q[i];
              b_q[i] <= '0;
            end
          end
          state_q <= ST_PIV;
        end
        ST_PIV: begin
          if (piv_val == '0) begin
            sing_q  <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            pv_q <= piv_val;
            for (int j = 0; j < STATE_DIM; j++) begin
              a_q[{piv, 2'(j)}]   <= a_q[{col_q, 2'(j)}];
              a_q[{col_q, 2'(j)}] <= a_q[{piv, 2'(j)}];
              b_q[{piv, 2'(j)}]   <= b_q[{col_q, 2'(j)}];
              b_q[{col_q, 2'(j)}] <= b_q[{piv, 2'(j)}];
            end
            state_q <= ST_DIVA;
          end
        end
        ST_DIVA: begin
          if (div_res[0].done) begin
            for (int j = 0; j < STATE_DIM; j++) begin
              hit = hit | div_res[j].sat;
              a_q[{col_q, 2'(j)}] <= div_res[j].quo;
            end
            state_q <= ST_DIVB;
          end
        end
        ST_DIVB: begin
          ph_q <= '0;
          e_q  <= '0;
          if (div_res[0].done) begin
            for (int j = 0; j < STATE_DIM; j++) begin
              hit = hit | div_res[j].sat;
              b_q[{col_q, 2'(j)}] <= div_res[j].quo;
            end
            state_q <= ST_ELIM;
          end
        end
        ST_ELIM: begin
          if (ph_q == 2'd0 && !eh) begin
            f_q <= a_q[{er, col_q}];
          end
          if (ph_q == 2'd2) begin
            if (er != col_q) begin
              for (int j = 0; j < STATE_DIM; j++) begin
                r0 = sat_w(SW'(lt[j]));
                hit = hit | r0[WORD_W];
                if (eh) begin
                  r1 = add_sat(b_q[{er, 2'(j)}], r0[WORD_W-1:0], 1'b1);
                  b_q[{er, 2'(j)}] <= r1[WORD_W-1:0];
                end else begin
                  r1 = add_sat(a_q[{er, 2'(j)}], r0[WORD_W-1:0], 1'b1);
                  a_q[{er, 2'(j)}] <= r1[WORD_W-1:0];
                end
                hit = hit | r1[WORD_W];
              end
            end
            if (e_q == 4'd7) begin
              e_q <= '0;
              if (col_q == 2'd3) begin
                state_q <= ST_MMK;
              end else begin
                col_q   <= col_q + 2'd1;
                state_q <= ST_PIV;
              end
            end
          end
        end
        ST_MMK: begin
          if (ph_q == 2'd2) begin
            hit = hit | sum_sat[WORD_W];
            k_q[e_q] <= sum_sat[WORD_W-1:0];
            if (e_q == 4'd15) state_q <= ST_NX;
          end
        end
        ST_NX: begin
          if (ph_q == 2'd2) begin
            hit = hit | sum_sat[WORD_W];
            r0 = add_sat(est_q[ej], sum_sat[WORD_W-1:0], 1'b0);
            hit = hit | r0[WORD_W];
            t_q[{2'd0, ej}] <= r0[WORD_W-1:0];
            if (e_q == 4'd3) state_q <= ST_IK;
          end
        end
        ST_IK: begin
          ph_q <= '0;
          e_q  <= '0;
          for (int i = 0; i < 16; i++) begin
            ts = add_sat((i % 5 == 0) ? ONE_FX : word_t'('0), k_q[i], 1'b1);
            hit = hit | ts[WORD_W];
            k_q[i] <= ts[WORD_W-1:0];
          end
          state_q <= ST_MMP;
        end
        ST_MMP: begin
          if (ph_q == 2'd2) begin
            hit = hit | sum_sat[WORD_W];
            a_q[e_q] <= sum_sat[WORD_W-1:0];
            if (e_q == 4'd15) state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          for (int i = 0; i < STATE_DIM; i++) begin
            est_q[i] <= t_q[i];
          end
          for (int i = 0; i < 16; i++) begin
            p_q[i] <= a_q[i];
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!(out_valid_q && out_stall_i)) begin
            for (int i = 0; i < STATE_DIM; i++) begin
              out_est_q[i] <= est_q[i];
            end
            out_sing_q  <= sing_q;
            out_sat_q   <= sat_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (hit) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign est_pos_x_o = out_est_q[0];
  assign est_pos_y_o = out_est_q[1];
  assign est_vel_x_o = out_est_q[2];
  assign est_vel_y_o = out_est_q[3];
  assign singular_o  = out_sing_q;
  assign saturated_o = out_sat_q;

  `CVKF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, state_q != ST_IDLE, "accepted transaction left the unit idle")
  `CVKF_ASSERT_IMPL(a_div_lanes_aligned, clk_i, rst_ni, div_res[0].done, div_res[1].done && div_res[2].done && div_res[3].done, "divide lanes out of step")
  `CVKF_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni, state_q == ST_DONE && !(out_valid_q && out_stall_i), out_valid_q && state_q == ST_IDLE, "finished transaction not delivered")
  `CVKF_ASSERT_IMPL(a_singular_on_update, clk_i, rst_ni, sing_q, cmd_q == CMD_UPDATE, "singular flag outside update")

endmodule
